// ===== rtl/assert_macros.svh =====
// Assertion helpers, included by rtl/text_cell_buffer_writer.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define TCB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define TCB_ASSERT_IMPL(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/tcb_pkg.sv =====
`default_nettype none
package tcb_pkg;
    localparam int COLUMNS = 78;
    localparam int ROWS    = 22;
    localparam int DEPTH   = COLUMNS * ROWS;
    localparam int CW      = $clog2(COLUMNS);
    localparam int RW      = $clog2(ROWS);
    localparam int AW      = $clog2(DEPTH);

    localparam logic [7:0] BYTE_ESC     = 8'h1B;
    localparam logic [7:0] BYTE_END_ESC = 8'h6D;
    localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
    localparam logic [7:0] BYTE_SPACE   = 8'h20;

    localparam logic FUNC_FEED = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Outcome of one fed byte.
    typedef struct packed {
        logic          esc;
        logic [CW-1:0] col;
        logic          adv;
        logic          wr;
    } t_feed;
endpackage
`default_nettype wire

// ===== rtl/tcb_ram.sv =====
`default_nettype none
module tcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== rtl/tcb_feed.sv =====
`default_nettype none
module tcb_feed (
    input  wire logic [7:0]           i_byte,
    input  wire logic                 i_esc,
    input  wire logic [tcb_pkg::CW-1:0] i_col,
    output tcb_pkg::t_feed            o_feed
);
    import tcb_pkg::*;

    // Decode one byte against the escape flag and cursor column.
    always_comb begin
        o_feed.esc = i_esc;
        o_feed.col = i_col;
        o_feed.adv = 1'b0;
        o_feed.wr  = 1'b0;
        if (i_byte == 8'h00) begin
            o_feed.esc = i_esc;
        end else if (i_byte == BYTE_END_ESC && i_esc) begin
            o_feed.esc = 1'b0;
        end else if (i_byte == BYTE_ESC) begin
            o_feed.esc = 1'b1;
        end else if (i_esc) begin
            o_feed.esc = 1'b1;
        end else if (i_byte == BYTE_NEWLINE) begin
            o_feed.col = '0;
            o_feed.adv = 1'b1;
        end else begin
            o_feed.wr = 1'b1;
            if (i_col == CW'(COLUMNS - 1)) begin
                o_feed.col = '0;
                o_feed.adv = 1'b1;
            end else begin
                o_feed.col = i_col + 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/text_cell_buffer_writer.sv =====
// Text cell store with cursor and upward scroll. Bytes fed with func 0 are written at
// the cursor (zero ignored, escape up to 'm' skipped, newline to the next row); a
// read item (func 1) returns one cell, 0 outside the grid. Every item gives one
// result carrying the cursor and escape flag after the item. The cells sit in one
// single-port-write RAM; rows are addressed through a rotating top-row pointer, so a
// scroll moves no data and only rewrites the new bottom row with spaces. A read item
// goes through a registered RAM read (S_READ) before its result, and a feed that
// scrolls is followed by S_SCRL, in which the RAM write port clears the COLUMNS (78)
// cells of the new bottom row one cell a cycle. After reset the block clears all DEPTH
// (1716) cells, one per cycle, before it takes the first item. A new item is taken only
// in S_IDLE, when the output register is empty or is being emptied in the same cycle.
`default_nettype none
module text_cell_buffer_writer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_func,
    input  wire logic [7:0] i_data_byte,
    input  wire logic [4:0] i_read_row,
    input  wire logic [6:0] i_read_col,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic      [7:0] o_cell_char,
    output logic      [6:0] o_cursor_col,
    output logic      [4:0] o_cursor_row,
    output logic            o_escape_active
);
    import tcb_pkg::*;

    localparam logic [1:0] S_INIT = 2'd0;  // clear every cell after reset
    localparam logic [1:0] S_IDLE = 2'd1;  // take items
    localparam logic [1:0] S_READ = 2'd2;  // wait for RAM read data
    localparam logic [1:0] S_SCRL = 2'd3;  // clear the new bottom row

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_line, n_line;
    logic          r_esc, n_esc;
    logic [RW-1:0] r_top, n_top;       // physical row shown as logical row 0
    logic [AW-1:0] r_base, n_base;     // RAM address of column 0 of the cursor row
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic [AW-1:0] r_clr_last, n_clr_last;
    logic          r_rd_oob, n_rd_oob;
    logic          r_ovld, n_ovld;
    logic [7:0]    r_ochar, n_ochar;

    t_feed         feed;
    logic          accept;
    logic          clearing;
    logic          scroll;
    logic [AW:0]   base_sum;
    logic [AW-1:0] base_next;
    logic [RW:0]   rrow_sum;
    logic [RW-1:0] rrow_phys;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    tcb_feed u_feed (
        .i_byte (i_data_byte),
        .i_esc  (r_esc),
        .i_col  (r_col),
        .o_feed (feed)
    );

    tcb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE) && (!r_ovld || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign clearing   = (r_state == S_INIT) || (r_state == S_SCRL);
    assign scroll     = feed.adv && (r_line == RW'(ROWS - 1));

    // Advance the cursor row base by one row, wrapping at the end of the RAM.
    assign base_sum  = {1'b0, r_base} + (AW + 1)'(COLUMNS);
    assign base_next = (base_sum >= (AW + 1)'(DEPTH)) ? AW'(base_sum - (AW + 1)'(DEPTH))
                                                      : AW'(base_sum);

    // Map the requested logical row onto its physical row.
    assign rrow_sum  = (RW + 1)'(RW'(i_read_row)) + (RW + 1)'(r_top);
    assign rrow_phys = (rrow_sum >= (RW + 1)'(ROWS)) ? RW'(rrow_sum - (RW + 1)'(ROWS))
                                                     : RW'(rrow_sum);

    assign ram_we    = clearing || (accept && i_func == FUNC_FEED && feed.wr);
    assign ram_waddr = clearing ? r_clr_addr : AW'(r_base + AW'(r_col));
    assign ram_wdata = clearing ? BYTE_SPACE : i_data_byte;
    assign ram_re    = accept && i_func == FUNC_READ;
    assign ram_raddr = AW'(rrow_phys * COLUMNS) + AW'(CW'(i_read_col));

    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_line     = r_line;
        n_esc      = r_esc;
        n_top      = r_top;
        n_base     = r_base;
        n_clr_addr = r_clr_addr;
        n_clr_last = r_clr_last;
        n_rd_oob   = r_rd_oob;
        n_ovld     = r_ovld;
        n_ochar    = r_ochar;
        if (r_ovld && i_out_ready) begin
            n_ovld = 1'b0;
        end
        case (r_state)
            S_INIT, S_SCRL: begin
                // Sweep one cell a cycle up to the last address of the pass.
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == r_clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && i_func == FUNC_FEED) begin
                    n_col   = feed.col;
                    n_esc   = feed.esc;
                    n_ovld  = 1'b1;
                    n_ochar = 8'h00;
                    if (feed.adv) begin
                        n_base = base_next;
                        if (scroll) begin
                            // Rotate the top row; the old top row becomes the bottom.
                            n_top      = (r_top == RW'(ROWS - 1)) ? '0 : r_top + 1'b1;
                            n_clr_addr = base_next;
                            n_clr_last = AW'(base_next + AW'(COLUMNS - 1));
                            n_state    = S_SCRL;
                        end else begin
                            n_line = r_line + 1'b1;
                        end
                    end
                end else if (accept) begin
                    n_rd_oob = (int'(i_read_row) >= ROWS) || (int'(i_read_col) >= COLUMNS);
                    n_state  = S_READ;
                end
            end
            S_READ: begin
                n_ovld  = 1'b1;
                n_ochar = r_rd_oob ? 8'h00 : ram_rdata;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_col      <= '0;
            r_line     <= '0;
            r_esc      <= 1'b0;
            r_top      <= '0;
            r_base     <= '0;
            r_clr_addr <= '0;
            r_clr_last <= AW'(DEPTH - 1);
            r_ovld     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_line     <= n_line;
            r_esc      <= n_esc;
            r_top      <= n_top;
            r_base     <= n_base;
            r_clr_addr <= n_clr_addr;
            r_clr_last <= n_clr_last;
            r_ovld     <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_oob <= n_rd_oob;
        r_ochar  <= n_ochar;
    end

    assign o_out_valid     = r_ovld;
    assign o_cell_char     = r_ochar;
    assign o_cursor_col    = 7'(r_col);
    assign o_cursor_row    = 5'(r_line);
    assign o_escape_active = r_esc;

`include "assert_macros.svh"

    `TCB_ASSERT(a_cursor_in_grid, i_clk, i_rst_n, (r_col < COLUMNS) && (r_line < ROWS))
    `TCB_ASSERT(a_base_in_ram, i_clk, i_rst_n, (r_base < DEPTH) && (r_top < ROWS))
    `TCB_ASSERT_IMPL(a_read_out_free, i_clk, i_rst_n, r_state == S_READ, !r_ovld)
    `TCB_ASSERT_IMPL(a_read_no_write, i_clk, i_rst_n, r_state == S_READ, !ram_we)

endmodule
`default_nettype wire

// ===== tb/text_cell_checker.sv =====
module text_cell_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_func,
    input  logic [7:0] i_data_byte,
    input  logic [4:0] i_read_row,
    input  logic [6:0] i_read_col,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_cell_char,
    input  logic [6:0] i_cursor_col,
    input  logic [4:0] i_cursor_row,
    input  logic       i_escape_active,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import tcb_pkg::*;

    localparam logic [7:0] BYTE_NUL = 8'h00;

    typedef struct packed {
        logic [7:0]    ch;
        logic [CW-1:0] col;
        logic [RW-1:0] row;
        logic          esc;
    } t_cell_view;

    logic [7:0]  screen [DEPTH];
    int unsigned cur_col;
    int unsigned cur_row;
    bit          skipping;
    t_cell_view  awaited [$];
    int          fails = 0;

    assign o_fail_count = fails;

    function automatic void wipe_screen();
        for (int i = 0; i < DEPTH; i++) screen[i] = BYTE_SPACE;
        cur_col  = 0;
        cur_row  = 0;
        skipping = 1'b0;
    endfunction

    // Move every row up by one and blank the bottom row.
    function automatic void scroll_up();
        for (int i = 0; i < DEPTH - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
        for (int i = DEPTH - COLUMNS; i < DEPTH; i++) screen[i] = BYTE_SPACE;
        cur_row = ROWS - 1;
    endfunction

    function automatic void feed_char(input logic [7:0] b);
        if (b == BYTE_NUL) return;
        if (b == BYTE_END_ESC && skipping) begin
            skipping = 1'b0;
            return;
        end
        if (b == BYTE_ESC) begin
            skipping = 1'b1;
            return;
        end
        if (skipping) return;
        if (b == BYTE_NEWLINE) begin
            cur_row++;
            cur_col = 0;
        end else begin
            if (cur_row < ROWS && cur_col < COLUMNS) screen[cur_row * COLUMNS + cur_col] = b;
            cur_col++;
            if (cur_col >= COLUMNS) begin
                cur_col = 0;
                cur_row++;
            end
        end
        if (cur_row >= ROWS) scroll_up();
    endfunction

    function automatic t_cell_view predict_cell(input logic f, input logic [7:0] b,
                                                input logic [4:0] r, input logic [6:0] c);
        t_cell_view v;
        v.ch = '0;
        if (f == FUNC_FEED) feed_char(b);
        else if (r < ROWS && c < COLUMNS) v.ch = screen[r * COLUMNS + c];
        v.col = cur_col[CW-1:0];
        v.row = cur_row[RW-1:0];
        v.esc = skipping;
        return v;
    endfunction

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            fails++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_cell_view want;
        if (!i_rst_n) begin
            wipe_screen();
            awaited.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                awaited.push_back(predict_cell(i_func, i_data_byte, i_read_row, i_read_col));
            if (i_out_valid && i_out_ready) begin
                if (awaited.size() == 0) begin
                    fails++;
                    $display("%0t: result with nothing expected: char %0d col %0d row %0d esc %0d",
                             $time, i_cell_char, i_cursor_col, i_cursor_row, i_escape_active);
                end else begin
                    want = awaited.pop_front();
                    check_field("cell_char", want.ch, i_cell_char);
                    check_field("cursor_col", want.col, i_cursor_col);
                    check_field("cursor_row", want.row, i_cursor_row);
                    check_field("escape_active", want.esc, i_escape_active);
                end
            end
        end
        o_pending <= awaited.size();
    end
endmodule

// ===== tb/tb_text_cell_buffer_writer.sv =====
module tb_text_cell_buffer_writer;
    timeunit 1ns;
    timeprecision 1ps;
    import tcb_pkg::*;

    // Run length and pacing.
    localparam int LIMIT        = 400000;  // watchdog, in clock cycles
    localparam int ITEM_TARGET  = 1200;    // random items after the directed part
    localparam int PHASE_ITEMS  = 150;     // items per idling phase
    localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
    localparam int HOLD_AT      = 400;     // item count that triggers the hold-off
    localparam int PAUSE_AT     = 800;     // item count that triggers the sender pause
    localparam int DRAIN_CYCLES = 200;     // covers a scroll clear after the last result

    // Bytes used to build escape sequences and text.
    localparam logic [7:0] CSI_OPEN   = "[";
    localparam logic [7:0] PARAM_SEP  = ";";
    localparam logic [7:0] DIGIT_ZERO = "0";
    localparam logic [7:0] TEXT_LAST  = "~";

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       i_func      = FUNC_FEED;
    logic [7:0] i_data_byte = '0;
    logic [4:0] i_read_row  = '0;
    logic [6:0] i_read_col  = '0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_cell_char;
    logic [6:0] o_cursor_col;
    logic [4:0] o_cursor_row;
    logic       o_escape_active;

    int          fail_count;
    int          pending;
    int unsigned items_sent     = 0;
    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left      = 0;
    int unsigned cycle_count    = 0;
    logic        hold_req       = 1'b0;
    logic        hold_done      = 1'b0;
    bit          hold_asked     = 1'b0;
    bit          pause_taken    = 1'b0;

    text_cell_buffer_writer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_data_byte     (i_data_byte),
        .i_read_row      (i_read_row),
        .i_read_col      (i_read_col),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_cell_char     (o_cell_char),
        .o_cursor_col    (o_cursor_col),
        .o_cursor_row    (o_cursor_row),
        .o_escape_active (o_escape_active)
    );

    text_cell_checker cell_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_data_byte     (i_data_byte),
        .i_read_row      (i_read_row),
        .i_read_col      (i_read_col),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_cell_char     (o_cell_char),
        .i_cursor_col    (o_cursor_col),
        .i_cursor_row    (o_cursor_row),
        .i_escape_active (o_escape_active),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog: end the run with failures once the cycle count reaches LIMIT.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side. Once asked, hold ready low for a long stretch so the
    // output register stays full and the block has to stall its input;
    // otherwise stall at the rate of the current idling phase.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one item and hold it until the block takes it. Valid is only
    // dropped inside a gap, so back-to-back items keep it high.
    task automatic send_item(input logic f, input logic [7:0] b,
                             input logic [4:0] r, input logic [6:0] c);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_func      <= f;
        i_data_byte <= b;
        i_read_row  <= r;
        i_read_col  <= c;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Feed items carry random row/column bits; read items carry a random byte.
    task automatic feed(input logic [7:0] b);
        send_item(FUNC_FEED, b, 5'($urandom), 7'($urandom));
    endtask

    task automatic read_cell(input logic [4:0] r, input logic [6:0] c);
        send_item(FUNC_READ, 8'($urandom), r, c);
    endtask

    // Drop valid and wait until every outstanding result has come back.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic set_mode(input t_idle_mode m);
        case (m)
            IDLE_NONE: begin
                send_gap_pct = 0;
                recv_stall_pct <= 0;
            end
            IDLE_SEND: begin
                send_gap_pct = 50;
                recv_stall_pct <= 0;
            end
            IDLE_RECV: begin
                send_gap_pct = 0;
                recv_stall_pct <= 50;
            end
            default: begin
                send_gap_pct = 8;
                recv_stall_pct <= 8;
            end
        endcase
    endtask

    function automatic logic [7:0] text_byte();
        return 8'($urandom_range(TEXT_LAST, BYTE_SPACE));
    endfunction

    function automatic logic [7:0] param_byte();
        if ($urandom_range(4) == 0) return PARAM_SEP;
        return 8'(DIGIT_ZERO + $urandom_range(9));
    endfunction

    // Most reads land near the bottom, where the cursor writes after the
    // first scroll; the rest cover the whole grid and the space outside it.
    function automatic logic [4:0] pick_row();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 60) return 5'(ROWS - 1 - $urandom_range(2));
        if (p < 85) return 5'($urandom_range(ROWS - 1));
        return 5'($urandom);
    endfunction

    function automatic logic [6:0] pick_col();
        if ($urandom_range(99) < 85) return 7'($urandom_range(COLUMNS - 1));
        return 7'($urandom);
    endfunction

    // Edge cases first: reads at the corners and off the grid, the zero byte,
    // escape handling in and out of a sequence, newline, extreme bytes.
    task automatic run_directed();
        read_cell(0, 0);
        read_cell(5'(ROWS - 1), 7'(COLUMNS - 1));
        read_cell(5'(ROWS), 0);
        read_cell(0, 7'(COLUMNS));
        read_cell('1, '1);
        feed('0);                 // zero byte: ignored
        feed("A");
        feed('1);
        feed(BYTE_END_ESC);       // 'm' outside a sequence is plain text
        feed(BYTE_ESC);
        feed(BYTE_ESC);           // escape inside a sequence keeps it open
        feed(BYTE_NEWLINE);       // swallowed while skipping
        feed('0);
        feed("X");
        feed(BYTE_END_ESC);       // closes the sequence
        feed(BYTE_NEWLINE);
        feed(8'h01);
        read_cell(0, 0);
        read_cell(0, 1);
        read_cell(0, 2);
        read_cell(1, 0);
        send_item(FUNC_READ, BYTE_ESC, 0, 3);  // the byte of a read item is unused
    endtask

    // One burst of well-formed traffic with random content, or some noise.
    task automatic random_burst();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 34) begin
            repeat ($urandom_range(12, 1)) feed(text_byte());
        end else if (pick < 48) begin
            repeat ($urandom_range(3, 1)) feed(BYTE_NEWLINE);
        end else if (pick < 58) begin
            // color sequence; leave one in five open at random
            feed(BYTE_ESC);
            feed(CSI_OPEN);
            repeat ($urandom_range(4, 1)) feed(param_byte());
            if ($urandom_range(4) != 0) feed(BYTE_END_ESC);
        end else if (pick < 83) begin
            repeat ($urandom_range(4, 1)) read_cell(pick_row(), pick_col());
        end else if (pick < 95) begin
            feed(8'($urandom));
        end else if (pick < 97) begin
            // long line: wrap past the last column for most lengths
            repeat ($urandom_range(2 * COLUMNS + 5, COLUMNS - 2)) feed(text_byte());
        end else begin
            read_cell(5'($urandom), 7'($urandom));
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        items_sent = 0;

        // Cycle through the idling phases; along the way hold off the
        // receiver once and pause the sender once until everything is back.
        while (items_sent < ITEM_TARGET) begin
            set_mode(t_idle_mode'((items_sent / PHASE_ITEMS) % 4));
            if (!hold_asked && items_sent >= HOLD_AT) begin
                hold_asked = 1'b1;
                hold_req <= 1'b1;
            end
            if (!pause_taken && items_sent >= PAUSE_AT) begin
                pause_taken = 1'b1;
                settle();
            end
            random_burst();
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
